// ----- rtl/page_framebuffer_rect_drawer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the page frame buffer drawer
// Wrap a labeled concurrent assertion with clock, async reset and a message.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_RECT_DRAWER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_RECT_DRAWER_ASSERT_SVH

// Same-cycle implication.
`define PFRD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrd_pkg
// Geometry constants, command codes and shared types of the drawer.
// ----------------------------------------------------------------------------
package pfrd_pkg;

  localparam int PANEL_WIDTH = 128;
  localparam int MAX_ROWS    = 64;
  localparam int PAGES       = MAX_ROWS / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES;

  localparam int AW     = $clog2(STORE_BYTES);
  localparam int XW     = $clog2(PANEL_WIDTH);
  localparam int XCW    = $clog2(PANEL_WIDTH + 1);
  localparam int YCW    = $clog2(MAX_ROWS + 1);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW     = $clog2(STORE_BYTES + 1);

  localparam int COORD_W     = 12;
  localparam int SW          = COORD_W + 1;
  localparam int MODE_W      = 3;
  localparam int RIDX_W      = 10;
  localparam int PH_W        = 7;
  localparam int DATA_W      = 8;
  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 8;

  localparam logic [PH_W-1:0] PH_RESET = PH_W'(64);

  localparam logic [MODE_W-1:0] MODE_SET     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FILL    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  localparam logic [DATA_W-1:0] FILL_ONES  = 8'hFF;
  localparam logic [DATA_W-1:0] FILL_ZEROS = 8'h00;

  localparam logic signed [SW-1:0] PW_S = SW'(PANEL_WIDTH);

  typedef struct packed {
    logic signed [SW-1:0] px;
    logic signed [SW-1:0] py;
    logic                 on;
  } plot_req_t;

  typedef struct packed {
    logic              ok;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] wdata;
  } plot_rsp_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } done_t;

endpackage

// ----- rtl/pfrd_ram.sv -----
// ----------------------------------------------------------------------------
// pfrd_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pfrd_plot.sv -----
// ----------------------------------------------------------------------------
// pfrd_plot
// Pixel unit: clip test, byte address, bit mask and merged write byte.
// ----------------------------------------------------------------------------
module pfrd_plot (
  input  pfrd_pkg::plot_req_t          req_i,
  input  logic [pfrd_pkg::YCW-1:0]     rows_i,
  input  logic [pfrd_pkg::DATA_W-1:0]  rdata_i,
  output pfrd_pkg::plot_rsp_t          rsp_o
);

  logic                          ok_x;
  logic                          ok_y;
  logic [pfrd_pkg::XW-1:0]       col;
  logic [pfrd_pkg::PAGE_W-1:0]   page;
  logic [pfrd_pkg::DATA_W-1:0]   mask;

  always_comb begin
    ok_x = !req_i.px[pfrd_pkg::SW-1] &&
           (req_i.px[pfrd_pkg::SW-2:0] < (pfrd_pkg::SW-1)'(pfrd_pkg::PANEL_WIDTH));
    ok_y = !req_i.py[pfrd_pkg::SW-1] &&
           (req_i.py[pfrd_pkg::SW-2:0] < (pfrd_pkg::SW-1)'(rows_i));
    col  = req_i.px[pfrd_pkg::XW-1:0];
    page = pfrd_pkg::PAGE_W'(req_i.py[pfrd_pkg::SW-1:3]);
    mask = pfrd_pkg::DATA_W'(1) << req_i.py[2:0];

    rsp_o.ok    = ok_x && ok_y;
    rsp_o.addr  = pfrd_pkg::AW'(col) + pfrd_pkg::AW'(page * pfrd_pkg::PANEL_WIDTH);
    rsp_o.wdata = req_i.on ? (rdata_i | mask) : (rdata_i & ~mask);
  end

endmodule

// ----- rtl/pfrd_seq.sv -----
// ----------------------------------------------------------------------------
// pfrd_seq
// Command sequencer: walks pixels or bytes and drives the store port.
// ----------------------------------------------------------------------------
module pfrd_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfrd_pkg::MODE_W-1:0]   mode_i,
  input  logic [pfrd_pkg::COORD_W-1:0]  pos_x_i,
  input  logic [pfrd_pkg::COORD_W-1:0]  pos_y_i,
  input  logic [pfrd_pkg::COORD_W-1:0]  rect_width_i,
  input  logic [pfrd_pkg::COORD_W-1:0]  rect_height_i,
  input  logic                          pixel_on_i,
  input  logic [pfrd_pkg::RIDX_W-1:0]   read_index_i,
  input  logic [pfrd_pkg::YCW-1:0]      rows_i,
  output pfrd_pkg::plot_req_t           plot_req_o,
  input  pfrd_pkg::plot_rsp_t           plot_rsp_i,
  output pfrd_pkg::ram_req_t            ram_req_o,
  input  logic [pfrd_pkg::DATA_W-1:0]   ram_rdata_i,
  output pfrd_pkg::done_t               done_o,
  input  logic                          out_free_i
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PWR   = 4'd4;
  localparam logic [3:0] S_CLR   = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWT   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] K_SET  = 2'd0;
  localparam logic [1:0] K_FILL = 2'd1;
  localparam logic [1:0] K_OUTH = 2'd2;
  localparam logic [1:0] K_OUTV = 2'd3;

  localparam int SW = pfrd_pkg::SW;

  function automatic logic signed [SW-1:0] from_x(input logic [pfrd_pkg::XCW-1:0] v);
    return signed'(SW'(v));
  endfunction

  function automatic logic signed [SW-1:0] from_y(input logic [pfrd_pkg::YCW-1:0] v);
    return signed'(SW'(v));
  endfunction

  logic [3:0]                          state_q, state_d;
  logic [1:0]                          kind_q, kind_d;
  logic                                sec_q, sec_d;
  logic [pfrd_pkg::CW-1:0]             cnt_q, cnt_d;
  logic signed [pfrd_pkg::COORD_W-1:0] x_q, y_q, w_q, h_q;
  logic                                on_q;
  logic [pfrd_pkg::RIDX_W-1:0]         ridx_q;
  logic signed [SW-1:0]                px_q, px_d, py_q, py_d;
  logic [pfrd_pkg::XCW-1:0]            i_q, i_d, x0_q, x1_q;
  logic [pfrd_pkg::YCW-1:0]            j_q, j_d, y0_q, y1_q;
  logic signed [SW-1:0]                xr_q, yb_q;
  logic                                yne_q;
  logic [pfrd_pkg::DATA_W-1:0]         res_q, res_d;

  logic                                accept;
  logic signed [SW-1:0]                xs, ys, xe, ye, x0s, x1s, y0s, y1s, rows_s;
  logic                                wpos, hpos, xne, yne;
  logic [pfrd_pkg::XCW-1:0]            i_nx;
  logic [pfrd_pkg::YCW-1:0]            j_nx;
  logic [pfrd_pkg::CW-1:0]             clear_end;
  logic                                rd_ok;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Rectangle bounds, clipped against the panel.
  always_comb begin
    xs     = SW'(x_q);
    ys     = SW'(y_q);
    xe     = SW'(x_q) + SW'(w_q);
    ye     = SW'(y_q) + SW'(h_q);
    rows_s = from_y(rows_i);
    x0s    = x_q[pfrd_pkg::COORD_W-1] ? '0 : xs;
    y0s    = y_q[pfrd_pkg::COORD_W-1] ? '0 : ys;
    x1s    = (xe > pfrd_pkg::PW_S) ? pfrd_pkg::PW_S : xe;
    y1s    = (ye > rows_s) ? rows_s : ye;
    wpos   = !w_q[pfrd_pkg::COORD_W-1] && (w_q != '0);
    hpos   = !h_q[pfrd_pkg::COORD_W-1] && (h_q != '0);
    xne    = x0s < x1s;
    yne    = y0s < y1s;
  end

  assign i_nx      = i_q + 1'b1;
  assign j_nx      = j_q + 1'b1;
  assign clear_end = pfrd_pkg::CW'((rows_i >> 3) * pfrd_pkg::PANEL_WIDTH);
  assign rd_ok     = 32'(ridx_q) < 32'(pfrd_pkg::STORE_BYTES);

  assign plot_req_o.px = px_q;
  assign plot_req_o.py = py_q;
  assign plot_req_o.on = on_q;

  assign done_o.valid = (state_q == S_DONE);
  assign done_o.data  = res_q;

  // Store port steering.
  always_comb begin
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = plot_rsp_i.addr;
    ram_req_o.wdata = plot_rsp_i.wdata;
    case (state_q)
      S_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = cnt_q[pfrd_pkg::AW-1:0];
        ram_req_o.wdata = pfrd_pkg::FILL_ZEROS;
      end
      S_CLR: begin
        ram_req_o.we    = cnt_q < clear_end;
        ram_req_o.addr  = cnt_q[pfrd_pkg::AW-1:0];
        ram_req_o.wdata = on_q ? pfrd_pkg::FILL_ONES : pfrd_pkg::FILL_ZEROS;
      end
      S_PWR: begin
        ram_req_o.we = plot_rsp_i.ok;
      end
      S_RRD: begin
        ram_req_o.addr = pfrd_pkg::AW'(ridx_q);
      end
      default: begin
        ram_req_o.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    sec_d   = sec_q;
    cnt_d   = cnt_q;
    px_d    = px_q;
    py_d    = py_q;
    i_d     = i_q;
    j_d     = j_q;
    res_d   = res_q;
    case (state_q)
      S_INIT: begin
        if (cnt_q == pfrd_pkg::CW'(pfrd_pkg::STORE_BYTES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          sec_d = 1'b0;
          cnt_d = '0;
          case (mode_i)
            pfrd_pkg::MODE_SET: begin
              kind_d  = K_SET;
              px_d    = SW'(signed'(pos_x_i));
              py_d    = SW'(signed'(pos_y_i));
              state_d = S_PRD;
            end
            pfrd_pkg::MODE_FILL: begin
              kind_d  = K_FILL;
              state_d = S_SETUP;
            end
            pfrd_pkg::MODE_OUTLINE: begin
              kind_d  = K_OUTH;
              state_d = S_SETUP;
            end
            pfrd_pkg::MODE_CLEAR: state_d = S_CLR;
            pfrd_pkg::MODE_READ:  state_d = S_RRD;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_SETUP: begin
        i_d     = pfrd_pkg::XCW'(x0s);
        j_d     = pfrd_pkg::YCW'(y0s);
        state_d = S_DONE;
        if (wpos && hpos) begin
          if (kind_q == K_FILL) begin
            if (xne && yne) begin
              px_d    = x0s;
              py_d    = y0s;
              state_d = S_PRD;
            end
          end else if (xne) begin
            px_d    = x0s;
            py_d    = ys;
            state_d = S_PRD;
          end else if (yne) begin
            kind_d  = K_OUTV;
            px_d    = xs;
            py_d    = y0s;
            state_d = S_PRD;
          end
        end
      end
      S_PRD: begin
        state_d = S_PWR;
      end
      S_PWR: begin
        state_d = S_PRD;
        case (kind_q)
          K_FILL: begin
            if (i_nx < x1_q) begin
              i_d  = i_nx;
              px_d = from_x(i_nx);
            end else if (j_nx < y1_q) begin
              i_d  = x0_q;
              j_d  = j_nx;
              px_d = from_x(x0_q);
              py_d = from_y(j_nx);
            end else begin
              state_d = S_DONE;
            end
          end
          K_OUTH: begin
            // Alternate top and bottom edge at each column.
            if (!sec_q) begin
              sec_d = 1'b1;
              py_d  = yb_q;
            end else begin
              sec_d = 1'b0;
              if (i_nx < x1_q) begin
                i_d  = i_nx;
                px_d = from_x(i_nx);
                py_d = ys;
              end else if (yne_q) begin
                kind_d = K_OUTV;
                j_d    = y0_q;
                px_d   = xs;
                py_d   = from_y(y0_q);
              end else begin
                state_d = S_DONE;
              end
            end
          end
          K_OUTV: begin
            // Alternate left and right edge at each row.
            if (!sec_q) begin
              sec_d = 1'b1;
              px_d  = xr_q;
            end else begin
              sec_d = 1'b0;
              if (j_nx < y1_q) begin
                j_d  = j_nx;
                px_d = xs;
                py_d = from_y(j_nx);
              end else begin
                state_d = S_DONE;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CLR: begin
        if (cnt_q < clear_end) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RRD: begin
        state_d = S_RWT;
      end
      S_RWT: begin
        res_d   = rd_ok ? ram_rdata_i : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      kind_q  <= K_SET;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      sec_q   <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    i_q   <= i_d;
    j_q   <= j_d;
    res_q <= res_d;
    if (accept) begin
      x_q    <= signed'(pos_x_i);
      y_q    <= signed'(pos_y_i);
      w_q    <= signed'(rect_width_i);
      h_q    <= signed'(rect_height_i);
      on_q   <= pixel_on_i;
      ridx_q <= read_index_i;
    end
    if (state_q == S_SETUP) begin
      x0_q  <= pfrd_pkg::XCW'(x0s);
      x1_q  <= pfrd_pkg::XCW'(x1s);
      y0_q  <= pfrd_pkg::YCW'(y0s);
      y1_q  <= pfrd_pkg::YCW'(y1s);
      xr_q  <= xe - SW'(1);
      yb_q  <= ye - SW'(1);
      yne_q <= yne;
    end
  end

endmodule

// ----- rtl/page_framebuffer_rect_drawer.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_rect_drawer
// One command at a time: set pixel, read byte, fill, outline and clear each
// run to the end before another is taken; fill and outline walk the clipped
// pixels, clear writes PANEL_WIDTH * pages bytes (one byte a cycle), all on
// the single store port.
// Reset: async active low; then a zeroing sweep of the whole store,
// with s_axis_tready low (configuration writes are taken throughout).
// ----------------------------------------------------------------------------
//
// Structure:
//   pfrd_seq  - command sequencer. Holds the latched command, the clipped
//               rectangle bounds and the pixel/byte walk counters.
//   pfrd_plot - the one pixel unit. Clips a coordinate pair, forms the
//               byte address x + page * PANEL_WIDTH and merges the bit.
//   pfrd_ram  - the frame store, one port, registered read.
//
// Every pixel is read, then written: S_PRD reads the byte, S_PWR writes back
// the merged byte. The store is never read and written for different pixels
// in the same cycle, so no forwarding is needed.
//
// Result words land in an output register. The sequencer parks in its done
// state until that register is free, and goes back to accepting commands
// while the last result still waits downstream.

module page_framebuffer_rect_drawer (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration: panel_height write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,     // panel_height

  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] pos_x, [23:12] pos_y, [35:24] rect_width, [47:36] rect_height,
  // [48] pixel_on, [58:49] read_index, [63:59] zero
  input  logic [63:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode

  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] read_data
);

  localparam int CWD = pfrd_pkg::COORD_W;

  logic [pfrd_pkg::PH_W-1:0]   ph_q;
  logic [pfrd_pkg::YCW-1:0]    rows;
  logic                        out_valid_q;
  logic [pfrd_pkg::DATA_W-1:0] out_data_q;
  logic                        out_free;
  logic [pfrd_pkg::DATA_W-1:0] ram_rdata;

  pfrd_pkg::plot_req_t plot_req;
  pfrd_pkg::plot_rsp_t plot_rsp;
  pfrd_pkg::ram_req_t  ram_req;
  pfrd_pkg::done_t     done;

  // Register write lands at once; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= pfrd_pkg::PH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ph_q <= cfg_data_i;
    end
  end

  // Saturate the row count at the store height.
  assign rows = (ph_q > pfrd_pkg::PH_W'(pfrd_pkg::MAX_ROWS)) ?
                pfrd_pkg::YCW'(pfrd_pkg::MAX_ROWS) : pfrd_pkg::YCW'(ph_q);

  pfrd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .mode_i        (s_axis_tuser),
    .pos_x_i       (s_axis_tdata[CWD-1:0]),
    .pos_y_i       (s_axis_tdata[2*CWD-1:CWD]),
    .rect_width_i  (s_axis_tdata[3*CWD-1:2*CWD]),
    .rect_height_i (s_axis_tdata[4*CWD-1:3*CWD]),
    .pixel_on_i    (s_axis_tdata[4*CWD]),
    .read_index_i  (s_axis_tdata[4*CWD+pfrd_pkg::RIDX_W:4*CWD+1]),
    .rows_i        (rows),
    .plot_req_o    (plot_req),
    .plot_rsp_i    (plot_rsp),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .done_o        (done),
    .out_free_i    (out_free)
  );

  pfrd_plot u_plot (
    .req_i   (plot_req),
    .rows_i  (rows),
    .rdata_i (ram_rdata),
    .rsp_o   (plot_rsp)
  );

  pfrd_ram #(
    .WIDTH (pfrd_pkg::DATA_W),
    .DEPTH (pfrd_pkg::STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // Output register: load a finished word when empty or being drained,
  // hold it otherwise.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid && out_free) begin
      out_data_q <= done.data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pfrd_pkg::TDATA_OUT_W'(out_data_q);

endmodule

// ----- rtl/pfrd_checker.sv -----
// ----------------------------------------------------------------------------
// pfrd_checker
// Port-level checks of the drawer, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_framebuffer_rect_drawer_assert.svh"

module pfrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_i,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_tvalid_i && s_tready_i;
  assign out_acc = m_tvalid_i && m_tready_i;

  // Track commands taken whose result word has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  `PFRD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_tready_i, "ready after accept")
  `PFRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i), "output word dropped or changed")
  `PFRD_ASSERT_NOW(a_no_invented, clk_i, rst_ni, m_tvalid_i, pend_q != 2'd0, "result without command")
  `PFRD_ASSERT_NOW(a_one_waiting, clk_i, rst_ni, s_tready_i, pend_q <= 2'd1, "ready with work pending")

endmodule

bind page_framebuffer_rect_drawer pfrd_checker u_pfrd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - page frame buffer drawer testbench
// Drives drawing commands into the command stream and checks each result word
// against a shadow copy of the page-organized store kept by the testbench.
// Directed tests hit the clipping edges, every command and odd panel heights;
// random traffic then runs under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import pfrd_pkg::*;

  // Command codes the block must ignore (no store change, zero answer).
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]     mode;
    logic signed [11:0]    px;
    logic signed [11:0]    py;
    logic signed [11:0]    w;
    logic signed [11:0]    h;
    logic                  on;
    logic [RIDX_W-1:0]     ridx;
  } draw_cmd_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [PH_W-1:0]        cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  // Shadow of the frame store and of the panel height register.
  logic [DATA_W-1:0] shadow_store [STORE_BYTES];
  logic [PH_W-1:0]   shadow_height;

  // Read words still owed by the block, oldest first.
  logic [DATA_W-1:0] owed_words [$];

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int words_checked;
  int height_writes;
  int mode_hits [8];

  page_framebuffer_rect_drawer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow drawing model
  // --------------------------------------------------------------------------

  // Heights above the store depth act as the full depth.
  function automatic int live_rows();
    int r;
    r = int'(shadow_height);
    return (r > MAX_ROWS) ? MAX_ROWS : r;
  endfunction

  // Set or clear one pixel; drop anything off the active panel.
  function automatic void shade_pixel(int x, int y, logic on);
    int idx;
    if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= live_rows()) return;
    idx = x + (y / 8) * PANEL_WIDTH;
    if (on) shadow_store[idx] = shadow_store[idx] | DATA_W'(1 << (y % 8));
    else    shadow_store[idx] = shadow_store[idx] & ~DATA_W'(1 << (y % 8));
  endfunction

  // Apply one command to the shadow store and return the word it answers.
  function automatic logic [DATA_W-1:0] apply_command(draw_cmd_t c);
    int x, y, w, h, x0, x1, y0, y1, n, i, j;
    logic [DATA_W-1:0] word;
    x = c.px;
    y = c.py;
    w = c.w;
    h = c.h;
    word = '0;
    x0 = (x < 0) ? 0 : x;
    x1 = (x + w > PANEL_WIDTH) ? PANEL_WIDTH : x + w;
    y0 = (y < 0) ? 0 : y;
    y1 = (y + h > live_rows()) ? live_rows() : y + h;
    case (c.mode)
      MODE_SET: begin
        shade_pixel(x, y, c.on);
      end
      MODE_FILL: begin
        if (w > 0 && h > 0) begin
          for (j = y0; j < y1; j++)
            for (i = x0; i < x1; i++) shade_pixel(i, j, c.on);
        end
      end
      MODE_OUTLINE: begin
        // Top and bottom rows first, then the two side columns; a width or
        // height of one draws the same edge twice.
        if (w > 0 && h > 0) begin
          for (i = x0; i < x1; i++) begin
            shade_pixel(i, y, c.on);
            shade_pixel(i, y + h - 1, c.on);
          end
          for (j = y0; j < y1; j++) begin
            shade_pixel(x, j, c.on);
            shade_pixel(x + w - 1, j, c.on);
          end
        end
      end
      MODE_CLEAR: begin
        // Only whole pages of the active height get cleared.
        n = PANEL_WIDTH * (live_rows() / 8);
        for (i = 0; i < n; i++) shadow_store[i] = c.on ? FILL_ONES : FILL_ZEROS;
      end
      MODE_READ: begin
        if (int'(c.ridx) < STORE_BYTES) word = shadow_store[c.ridx];
      end
      default: ;
    endcase
    return word;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic draw_cmd_t make_cmd(logic [MODE_W-1:0] mode, int x, int y,
                                         int w, int h, logic on, int ridx);
    draw_cmd_t c;
    c.mode = mode;
    c.px   = 12'(x);
    c.py   = 12'(y);
    c.w    = 12'(w);
    c.h    = 12'(h);
    c.on   = on;
    c.ridx = RIDX_W'(ridx);
    return c;
  endfunction

  // Coordinate a few pixels either side of a panel span.
  function automatic logic [11:0] near_coord(int span);
    return 12'(int'($urandom_range(span + 15)) - 8);
  endfunction

  // Length from -2 up to maxlen.
  function automatic logic [11:0] short_len(int maxlen);
    return 12'(int'($urandom_range(maxlen + 2)) - 2);
  endfunction

  // Mostly well-formed commands near the panel, with some full-range noise.
  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int unsigned pick, shape;
    c.px   = 12'($urandom);
    c.py   = 12'($urandom);
    c.w    = 12'($urandom);
    c.h    = 12'($urandom);
    c.on   = 1'($urandom);
    c.ridx = RIDX_W'($urandom);
    pick   = $urandom_range(99);
    shape  = $urandom_range(99);
    if (pick < 25) begin
      c.mode = MODE_SET;
      if (shape >= 15) begin
        c.px = near_coord(PANEL_WIDTH);
        c.py = near_coord(MAX_ROWS);
      end
    end else if (pick < 43) begin
      // Keep clipped areas mostly small: a full-range side gets a short other side.
      c.mode = MODE_FILL;
      if (shape < 2) begin
        c.px = near_coord(PANEL_WIDTH);
        c.py = near_coord(MAX_ROWS);
        c.w  = 12'($urandom_range(2047, 64));
        c.h  = 12'($urandom_range(2047, 64));
      end else if (shape < 7) begin
        c.h = short_len(8);
      end else if (shape < 12) begin
        c.w = short_len(8);
      end else begin
        c.px = near_coord(PANEL_WIDTH);
        c.py = near_coord(MAX_ROWS);
        c.w  = short_len(16);
        c.h  = short_len(16);
      end
    end else if (pick < 57) begin
      c.mode = MODE_OUTLINE;
      if (shape >= 30) begin
        c.px = near_coord(PANEL_WIDTH);
        c.py = near_coord(MAX_ROWS);
        c.w  = short_len(20);
        c.h  = short_len(20);
      end
    end else if (pick < 60) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 94) begin
      c.mode = MODE_READ;
    end else if (shape < 33) begin
      c.mode = MODE_RSVD5;
    end else if (shape < 66) begin
      c.mode = MODE_RSVD6;
    end else begin
      c.mode = MODE_RSVD7;
    end
    return c;
  endfunction

  // Send one command word and record the word it must answer. Valid stays
  // high on return so back-to-back words never drop it for a step.
  task automatic push_command(input draw_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, c.ridx, c.on, c.h, c.w, c.py, c.px};
    s_axis_tuser  <= c.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    owed_words.push_back(apply_command(c));
    mode_hits[c.mode]++;
  endtask

  task automatic read_byte(input int idx);
    push_command(make_cmd(MODE_READ, 0, 0, 0, 0, 1'b0, idx));
  endtask

  // Drop valid and hold until every owed word has come back, plus a margin.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_panel_height(input logic [PH_W-1:0] rows);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rows;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    shadow_height = rows;
    height_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    logic [DATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual 0x%02h",
                 $time, m_axis_tdata);
        err_count++;
      end else begin
        want = owed_words.pop_front();
        words_checked++;
        if (m_axis_tdata !== want) begin
          $display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
                   $time, want, m_axis_tdata);
          err_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner pixels and far out-of-range coordinates.
  task automatic test_pixel_ops();
    push_command(make_cmd(MODE_SET, 0, 0, 0, 0, 1'b1, 0));
    push_command(make_cmd(MODE_SET, PANEL_WIDTH - 1, MAX_ROWS - 1, 0, 0, 1'b1, 0));
    push_command(make_cmd(MODE_SET, -2048, 2047, 0, 0, 1'b1, 0));
    push_command(make_cmd(MODE_SET, 2047, -2048, 0, 0, 1'b0, 0));
    read_byte(0);
    read_byte(STORE_BYTES - 1);
  endtask

  // Clipped fills, empty sizes and outlines of width one and off the edge.
  task automatic test_rect_ops();
    push_command(make_cmd(MODE_FILL, -3, -3, 8, 12, 1'b1, 0));
    push_command(make_cmd(MODE_FILL, 20, 20, 0, -2048, 1'b1, 0));
    push_command(make_cmd(MODE_FILL, -2048, -2048, 2047, 2047, 1'b1, 0));
    push_command(make_cmd(MODE_OUTLINE, 10, 10, 1, 1, 1'b1, 0));
    push_command(make_cmd(MODE_OUTLINE, 120, 60, 2047, 2047, 1'b1, 0));
    read_byte(PANEL_WIDTH + 10);
    read_byte(7 * PANEL_WIDTH + 120);
  endtask

  // Clear to ones, then check the ignored codes leave the store alone.
  task automatic test_clear_and_unused();
    push_command(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b1, 0));
    push_command(make_cmd(MODE_RSVD5, 1, 1, 4, 4, 1'b0, 512));
    push_command(make_cmd(MODE_RSVD6, 1, 1, 4, 4, 1'b0, 512));
    push_command(make_cmd(MODE_RSVD7, 1, 1, 4, 4, 1'b0, 512));
    read_byte(512);
  endtask

  // Height that is not a multiple of eight, above the limit and below eight.
  task automatic test_panel_height();
    write_panel_height(PH_W'(13));
    push_command(make_cmd(MODE_SET, 0, 13, 0, 0, 1'b0, 0));
    push_command(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    read_byte(5 * PANEL_WIDTH);
    write_panel_height(PH_W'(127));
    push_command(make_cmd(MODE_SET, 3, MAX_ROWS - 1, 0, 0, 1'b0, 0));
    read_byte(7 * PANEL_WIDTH + 3);
    write_panel_height(PH_W'(3));
    push_command(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    read_byte(PANEL_WIDTH + 5);
    write_panel_height(PH_RESET);
  endtask

  // Random traffic in three chunks, one panel height per chunk.
  task automatic test_random_traffic(input int items, input int s_pct, input int r_pct,
                                     input logic [PH_W-1:0] h0, input logic [PH_W-1:0] h1,
                                     input logic [PH_W-1:0] h2);
    logic [PH_W-1:0] heights [3];
    heights[0] = h0;
    heights[1] = h1;
    heights[2] = h2;
    foreach (heights[k]) begin
      write_panel_height(heights[k]);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (items / 3) push_command(random_command());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_height = PH_RESET;
    send_idle_pct = 28;
    recv_idle_pct = 72;
    err_count     = 0;
    words_checked = 0;
    height_writes = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pixel_ops();
    test_rect_ops();
    test_clear_and_unused();
    test_panel_height();

    test_random_traffic(483, 28, 72, PH_W'(64), PH_W'(8), PH_W'(0));
    test_random_traffic(483, 72, 28, PH_W'(127), PH_W'(13),
                        PH_W'($urandom_range(127)));
    test_random_traffic(483, 0, 0, PH_W'(5), PH_W'(56), PH_W'(64));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (owed_words.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, owed_words.size());
      err_count++;
    end

    $display("covered %0d set, %0d fill, %0d outline, %0d clear, %0d read, %0d ignored",
             mode_hits[MODE_SET], mode_hits[MODE_FILL], mode_hits[MODE_OUTLINE],
             mode_hits[MODE_CLEAR], mode_hits[MODE_READ],
             mode_hits[MODE_RSVD5] + mode_hits[MODE_RSVD6] + mode_hits[MODE_RSVD7]);
    $display("%0d result words checked across %0d panel height writes",
             words_checked, height_writes);

    if (err_count == 0) begin
      $display("page_framebuffer_rect_drawer test passed");
    end else begin
      $display("page_framebuffer_rect_drawer test failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d result words outstanding", $time, owed_words.size());
    $display("page_framebuffer_rect_drawer test failed");
    $finish;
  end

endmodule
